FILE: sv/pol_pkg.sv
// Shared types and fixed field widths for the positional ordered list.
// No dependencies; imported by pol_decode and positional_ordered_list.
package pol_pkg;

  localparam int POS_W  = 7;   // in_position width
  localparam int HIN_W  = 16;  // in_handle_in width
  localparam int HOUT_W = 16;  // out_handle_out width
  localparam int LEN_W  = 7;   // out_list_length width

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_GET    = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // request check result: err -> reject, run -> needs the memory engine
  typedef struct packed {
    logic err;
    logic run;
  } dec_t;

endpackage

FILE: sv/pol_decode.sv
// Range, null and full checks for an incoming list request.
// Depends on pol_pkg (kind_t, dec_t, POS_W).
module pol_decode import pol_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int CNT_W    = 7
) (
  input  logic [1:0]       kind,
  input  logic [POS_W-1:0] position,
  input  logic             handle_zero,
  input  logic [CNT_W-1:0] cnt,
  output dec_t             dec
);

  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(cnt);
  assign full    = (cnt >= CNT_W'(CAPACITY));

  always_comb begin
    dec = '0;
    case (kind_t'(kind))
      KIND_INSERT: begin
        dec.err = (pos_ext > cnt_ext) || handle_zero || full;
        dec.run = !dec.err;
      end
      KIND_DELETE, KIND_GET: begin
        dec.err = (pos_ext >= cnt_ext);
        dec.run = !dec.err;
      end
      KIND_CLEAR: begin
        dec.err = 1'b0;
        dec.run = 1'b0;
      end
      default: begin
        dec.err = 1'b1;
        dec.run = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/positional_ordered_list.sv
// Positional ordered list: top level with the entry memory and shift engine.
// Depends on pol_pkg and pol_decode.
//
// Usage: a request (in_kind, in_position, in_handle_in) is taken at a rising
// edge with start high and busy low. Each request yields one result on
// out_status, out_handle_out and out_list_length, shown for exactly one cycle
// with out_strobe high; the receiver cannot stall it.
// Errors and clear: the strobe comes in the cycle after acceptance.
// Get: the entry is read, then captured, then the strobe is shown.
// Insert/delete: R = length - position reads through the single-port-read
// memory, one per cycle, shifted one place by write-back; then the strobe
// comes. An insert at the end of the list (R = 0) needs no reads.
// The read-then-write-back shift loop over the entry memory sets the time, so
// a request takes longer the more entries it shifts. busy is high while the
// engine runs; the next request may be taken in the cycle the strobe is shown.
// Reset (synchronous, active low) empties the list at once; the memory
// itself is not cleared, only entries below the length are ever read.
module positional_ordered_list import pol_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_kind,
  input  logic [POS_W-1:0]  in_position,
  input  logic [HIN_W-1:0]  in_handle_in,
  output logic              out_strobe,
  output logic              out_status,
  output logic [HOUT_W-1:0] out_handle_out,
  output logic [LEN_W-1:0]  out_list_length
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int HI_W   = (HANDLE_BITS > HIN_W) ? HANDLE_BITS : HIN_W;
  localparam int HO_W   = (HANDLE_BITS > HOUT_W) ? HANDLE_BITS : HOUT_W;
  localparam int LX_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [HANDLE_BITS-1:0] mem [CAPACITY];

  state_t                 state_r, state_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [CNT_W-1:0]       pos_r, pos_nxt;
  logic [HANDLE_BITS-1:0] handle_r, handle_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic                   pend_r, pend_nxt;
  logic                   first_r, first_nxt;
  logic [HANDLE_BITS-1:0] taken_r, taken_nxt;
  logic [HANDLE_BITS-1:0] rd_data_r;

  logic                   out_strobe_r, out_strobe_nxt;
  logic                   out_status_r, out_status_nxt;
  logic [HOUT_W-1:0]      out_handle_r, out_handle_nxt;
  logic [LEN_W-1:0]       out_len_r, out_len_nxt;

  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_wa;
  logic [HANDLE_BITS-1:0] mem_wd;
  logic                   rd_en;

  logic [HI_W-1:0]        hin_ext;
  logic [HANDLE_BITS-1:0] hin;
  logic [CMP_W-1:0]       pos_ext;
  logic [HO_W-1:0]        taken_ext;
  logic [LX_W-1:0]        cnt_nxt_ext;
  logic                   accept;
  logic                   finish;
  dec_t                   dec;

  assign hin_ext   = HI_W'(in_handle_in);
  assign hin       = hin_ext[HANDLE_BITS-1:0];
  assign pos_ext   = CMP_W'(in_position);
  assign taken_ext = HO_W'(taken_r);
  assign accept    = start && (state_r == ST_IDLE);
  assign finish    = (state_r == ST_RUN) && (rem_r == '0) && !pend_r;

  pol_decode #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_decode (
    .kind        (in_kind),
    .position    (in_position),
    .handle_zero (hin == '0),
    .cnt         (cnt_r),
    .dec         (dec)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && dec.run) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (finish) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_nxt       = kind_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    handle_nxt     = handle_r;
    rem_nxt        = rem_r;
    rd_ptr_nxt     = rd_ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    pend_nxt       = pend_r;
    first_nxt      = first_r;
    taken_nxt      = taken_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    rd_en          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (dec.run) begin
            kind_nxt   = kind_t'(in_kind);
            pos_nxt    = pos_ext[CNT_W-1:0];
            handle_nxt = hin;
            pend_nxt   = 1'b0;
            case (kind_t'(in_kind))
              KIND_INSERT: begin
                // move entries pos..cnt-1 up by one, top first
                rem_nxt    = cnt_r - pos_ext[CNT_W-1:0];
                rd_ptr_nxt = cnt_r - CNT_W'(1);
                wr_ptr_nxt = cnt_r;
                first_nxt  = 1'b0;
              end
              KIND_DELETE: begin
                // first read is the removed entry, the rest move down
                rem_nxt    = cnt_r - pos_ext[CNT_W-1:0];
                rd_ptr_nxt = pos_ext[CNT_W-1:0];
                wr_ptr_nxt = pos_ext[CNT_W-1:0];
                first_nxt  = 1'b1;
              end
              default: begin
                rem_nxt    = CNT_W'(1);
                rd_ptr_nxt = pos_ext[CNT_W-1:0];
                wr_ptr_nxt = pos_ext[CNT_W-1:0];
                first_nxt  = 1'b1;
              end
            endcase
          end else begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = dec.err;
            out_handle_nxt = '0;
            if (!dec.err) cnt_nxt = '0;  // clear
          end
        end
      end
      ST_RUN: begin
        if (pend_r) begin
          if (first_r) begin
            taken_nxt = rd_data_r;
            first_nxt = 1'b0;
          end else begin
            mem_we = 1'b1;
            mem_wa = wr_ptr_r[ADDR_W-1:0];
            mem_wd = rd_data_r;
            if (kind_r == KIND_INSERT) wr_ptr_nxt = wr_ptr_r - CNT_W'(1);
            else                       wr_ptr_nxt = wr_ptr_r + CNT_W'(1);
          end
        end
        if (rem_r != '0) begin
          rd_en    = 1'b1;
          rem_nxt  = rem_r - CNT_W'(1);
          pend_nxt = 1'b1;
          if (kind_r == KIND_INSERT) rd_ptr_nxt = rd_ptr_r - CNT_W'(1);
          else                       rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (finish) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = 1'b0;
          case (kind_r)
            KIND_INSERT: begin
              mem_we         = 1'b1;
              mem_wa         = pos_r[ADDR_W-1:0];
              mem_wd         = handle_r;
              cnt_nxt        = cnt_r + CNT_W'(1);
              out_handle_nxt = '0;
            end
            KIND_DELETE: begin
              cnt_nxt        = cnt_r - CNT_W'(1);
              out_handle_nxt = taken_ext[HOUT_W-1:0];
            end
            default: begin
              out_handle_nxt = taken_ext[HOUT_W-1:0];
            end
          endcase
        end
      end
      default: ;
    endcase
    cnt_nxt_ext = LX_W'(cnt_nxt);
    out_len_nxt = out_strobe_nxt ? cnt_nxt_ext[LEN_W-1:0] : out_len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      rem_r        <= '0;
      pend_r       <= 1'b0;
      first_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rem_r        <= rem_nxt;
      pend_r       <= pend_nxt;
      first_r      <= first_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    handle_r     <= handle_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    wr_ptr_r     <= wr_ptr_nxt;
    taken_r      <= taken_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_len_r    <= out_len_nxt;
  end

  // entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_data_r <= mem[rd_ptr_r[ADDR_W-1:0]];
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_status      = out_status_r;
  assign out_handle_out  = out_handle_r;
  assign out_list_length = out_len_r;

  // a result is never shown while the engine still runs
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("list length above capacity");

  // shift write-back never targets the entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && rd_en) |-> (mem_wa != rd_ptr_r[ADDR_W-1:0]))
    else $error("read and write of one entry in one cycle");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_CLEAR)) |=>
      (out_strobe && !out_status && (out_list_length == '0)))
    else $error("clear transaction result wrong");

endmodule
